// File: sv/brs_pkg.sv
package brs_pkg;

   // Fixed field widths
   localparam int COORD_W   = 19;
   localparam int PIX_W     = 24;
   localparam int CH_W      = 8;
   localparam int NUM_CH    = 3;
   localparam int POS_IN_W  = 9;
   localparam int CFG_W     = 10;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_BANKS = 4;

   // Parameter defaults
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int DIM_RESET      = 512;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_MODE   = 2'd2;

   // Item and color codes
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;
   localparam logic COLOR_GREY  = 1'b0;
   localparam logic COLOR_RGB   = 1'b1;

   // Control that travels with a sample from the address stage to the blend stages
   typedef struct packed {
      logic valid;
      logic in_frame;
      logic x_odd;
      logic y_odd;
   } brs_ctrl_type;

   // Width/height below 2 acts as 2, above the maximum acts as the maximum
   function automatic int clamp_dim(input int v, input int maxv);
      int r;
      r = v;
      if (v < 2) r = 2;
      else if (v > maxv) r = maxv;
      return r;
   endfunction

endpackage

// File: sv/brs_ram.sv
module brs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/brs_front.sv
module brs_front import brs_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int DIM_W     = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1),
   localparam int HALF_W    = (MAX_WIDTH + 1) / 2,
   localparam int HALF_H    = (MAX_HEIGHT + 1) / 2,
   localparam int BANK_DEPTH = HALF_W * HALF_H,
   localparam int BA_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1,
   localparam int WT_W      = 2 * FRAC_BITS + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                req_mode,
   input  logic [POS_IN_W-1:0] req_write_col,
   input  logic [POS_IN_W-1:0] req_write_row,
   input  logic [PIX_W-1:0]    req_pixel_in,
   input  logic signed [COORD_W-1:0] req_sample_x,
   input  logic signed [COORD_W-1:0] req_sample_y,
   input  logic [DIM_W-1:0]    frame_width,
   input  logic [DIM_W-1:0]    frame_height,
   output logic [BA_W-1:0]     bank_addr [NUM_BANKS],
   output logic [NUM_BANKS-1:0] bank_wr_en,
   output logic [PIX_W-1:0]    bank_wr_data,
   output brs_ctrl_type        ctrl,
   output logic [WT_W-1:0]     weight [4]
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int CMP_W = (DIM_W + FRAC_BITS > COORD_W - 1) ? DIM_W + FRAC_BITS : COORD_W - 1;
   localparam int WB_W  = FRAC_BITS + 1;
   localparam int ONE   = 1 << FRAC_BITS;

   // Stage 1: captured transaction
   logic                s1_valid_ff;
   logic                s1_mode_ff;
   logic [POS_IN_W-1:0] s1_col_ff;
   logic [POS_IN_W-1:0] s1_row_ff;
   logic [PIX_W-1:0]    s1_pix_ff;
   logic signed [COORD_W-1:0] s1_x_ff;
   logic signed [COORD_W-1:0] s1_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_mode_ff <= req_mode;
      s1_col_ff  <= req_write_col;
      s1_row_ff  <= req_write_row;
      s1_pix_ff  <= req_pixel_in;
      s1_x_ff    <= req_sample_x;
      s1_y_ff    <= req_sample_y;
   end

   // Stage 1 decode: bounds checks, integer and fraction split
   logic            s2_sample_in;
   logic            s2_in_frame_in;
   logic            s2_wr_ok_in;
   logic [CW-1:0]   s2_col_in;
   logic [RW-1:0]   s2_row_in;
   logic [CMP_W-1:0] xlim;
   logic [CMP_W-1:0] ylim;
   logic            x_in;
   logic            y_in;

   always_comb begin
      xlim = CMP_W'(frame_width - 1'b1) << FRAC_BITS;
      ylim = CMP_W'(frame_height - 1'b1) << FRAC_BITS;
      x_in = !s1_x_ff[COORD_W-1] && (CMP_W'(s1_x_ff[COORD_W-2:0]) < xlim);
      y_in = !s1_y_ff[COORD_W-1] && (CMP_W'(s1_y_ff[COORD_W-2:0]) < ylim);
      s2_sample_in   = (s1_mode_ff == MODE_SAMPLE);
      s2_in_frame_in = x_in && y_in;
      s2_wr_ok_in  = (CMP_W'(s1_col_ff) < CMP_W'(frame_width)) &&
                     (CMP_W'(s1_row_ff) < CMP_W'(frame_height));
      if (s2_sample_in) begin
         s2_col_in = CW'(s1_x_ff[COORD_W-2:0] >> FRAC_BITS);
         s2_row_in = RW'(s1_y_ff[COORD_W-2:0] >> FRAC_BITS);
      end else begin
         s2_col_in = CW'(s1_col_ff);
         s2_row_in = RW'(s1_row_ff);
      end
   end

   // Stage 2: decoded transaction
   logic                 s2_valid_ff;
   logic                 s2_sample_ff;
   logic                 s2_in_frame_ff;
   logic                 s2_wr_ok_ff;
   logic [CW-1:0]        s2_col_ff;
   logic [RW-1:0]        s2_row_ff;
   logic [FRAC_BITS-1:0] s2_dx_ff;
   logic [FRAC_BITS-1:0] s2_dy_ff;
   logic [PIX_W-1:0]     s2_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_sample_ff   <= s2_sample_in;
      s2_in_frame_ff <= s2_in_frame_in;
      s2_wr_ok_ff    <= s2_wr_ok_in;
      s2_col_ff      <= s2_col_in;
      s2_row_ff      <= s2_row_in;
      s2_dx_ff       <= s1_x_ff[FRAC_BITS-1:0];
      s2_dy_ff       <= s1_y_ff[FRAC_BITS-1:0];
      s2_pix_ff      <= s1_pix_ff;
   end

   // Bank addressing: bank {row parity, col parity}; each bank holds one neighbor
   always_comb begin
      logic [1:0]    bsel;
      logic [CW-1:0] colb;
      logic [RW-1:0] rowb;
      for (int b = 0; b < NUM_BANKS; b++) begin
         bsel = 2'(b);
         colb = (s2_col_ff[0] == bsel[0]) ? s2_col_ff : s2_col_ff + 1'b1;
         rowb = (s2_row_ff[0] == bsel[1]) ? s2_row_ff : s2_row_ff + 1'b1;
         bank_addr[b] = BA_W'(rowb >> 1) * BA_W'(HALF_H > 0 ? HALF_W : 1) + BA_W'(colb >> 1);
         bank_wr_en[b] = s2_valid_ff && !s2_sample_ff && s2_wr_ok_ff &&
                         (bsel == {s2_row_ff[0], s2_col_ff[0]});
      end
   end

   assign bank_wr_data = s2_pix_ff;

   // Bilinear weights
   logic [WB_W-1:0] ndx;
   logic [WB_W-1:0] ndy;

   always_comb begin
      ndx = WB_W'(ONE) - WB_W'(s2_dx_ff);
      ndy = WB_W'(ONE) - WB_W'(s2_dy_ff);
      weight[0] = WT_W'(ndx) * WT_W'(ndy);
      weight[1] = WT_W'(s2_dx_ff) * WT_W'(ndy);
      weight[2] = WT_W'(ndx) * WT_W'(s2_dy_ff);
      weight[3] = WT_W'(s2_dx_ff) * WT_W'(s2_dy_ff);
   end

   always_comb begin
      ctrl.valid    = s2_valid_ff && s2_sample_ff;
      ctrl.in_frame = s2_in_frame_ff;
      ctrl.x_odd    = s2_col_ff[0];
      ctrl.y_odd    = s2_row_ff[0];
   end

endmodule

// File: sv/brs_blend.sv
module brs_blend import brs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int WT_W     = 2 * FRAC_BITS + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [PIX_W-1:0] bank_data [NUM_BANKS],
   input  brs_ctrl_type     ctrl,
   input  logic [WT_W-1:0]  weight [4],
   input  logic             color_mode,
   output logic             rsp_valid,
   output logic [PIX_W-1:0] rsp_pixel_out,
   output logic             rsp_inside_res
);

   localparam int PROD_W = WT_W + CH_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int SH     = 2 * FRAC_BITS;
   localparam int Q_W    = SUM_W - SH;

   // Stage 3: weights aligned with the registered bank reads
   brs_ctrl_type    s3_ctrl_ff;
   logic [WT_W-1:0] s3_wt_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctrl_ff.valid <= 1'b0;
      end else begin
         s3_ctrl_ff.valid <= ctrl.valid;
      end
      s3_ctrl_ff.in_frame <= ctrl.in_frame;
      s3_ctrl_ff.x_odd    <= ctrl.x_odd;
      s3_ctrl_ff.y_odd    <= ctrl.y_odd;
      s3_wt_ff            <= weight;
   end

   // Route banks to neighbors and form per-channel products
   logic [PROD_W-1:0] prod_in [NUM_CH][4];

   always_comb begin
      logic [1:0]       bsel;
      logic [PIX_W-1:0] nb;
      for (int n = 0; n < 4; n++) begin
         bsel = {s3_ctrl_ff.y_odd, s3_ctrl_ff.x_odd} ^ 2'(n);
         nb = bank_data[bsel];
         for (int c = 0; c < NUM_CH; c++) begin
            prod_in[c][n] = PROD_W'(s3_wt_ff[n]) * PROD_W'(nb[c*CH_W +: CH_W]);
         end
      end
   end

   // Stage 4: products
   brs_ctrl_type      s4_ctrl_ff;
   logic [PROD_W-1:0] s4_prod_ff [NUM_CH][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctrl_ff.valid <= 1'b0;
      end else begin
         s4_ctrl_ff.valid <= s3_ctrl_ff.valid;
      end
      s4_ctrl_ff.in_frame <= s3_ctrl_ff.in_frame;
      s4_ctrl_ff.x_odd    <= s3_ctrl_ff.x_odd;
      s4_ctrl_ff.y_odd    <= s3_ctrl_ff.y_odd;
      s4_prod_ff          <= prod_in;
   end

   // Sum the four neighbors per channel
   logic [SUM_W-1:0] sum_in [NUM_CH];

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         sum_in[c] = SUM_W'(s4_prod_ff[c][0]) + SUM_W'(s4_prod_ff[c][1]) +
                     SUM_W'(s4_prod_ff[c][2]) + SUM_W'(s4_prod_ff[c][3]);
      end
   end

   // Stage 5: sums
   brs_ctrl_type     s5_ctrl_ff;
   logic [SUM_W-1:0] s5_sum_ff [NUM_CH];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ctrl_ff.valid <= 1'b0;
      end else begin
         s5_ctrl_ff.valid <= s4_ctrl_ff.valid;
      end
      s5_ctrl_ff.in_frame <= s4_ctrl_ff.in_frame;
      s5_ctrl_ff.x_odd    <= s4_ctrl_ff.x_odd;
      s5_ctrl_ff.y_odd    <= s4_ctrl_ff.y_odd;
      s5_sum_ff           <= sum_in;
   end

   // Round to nearest, ties to even, clamp to 255; mask outside and grey channels
   logic [PIX_W-1:0] pix_in;

   always_comb begin
      logic [Q_W-1:0] q;
      logic [SH-1:0]  r;
      logic [Q_W:0]   qr;
      logic           up;
      pix_in = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         q  = s5_sum_ff[c][SUM_W-1:SH];
         r  = s5_sum_ff[c][SH-1:0];
         up = (r > (SH'(1) << (SH - 1))) || ((r == (SH'(1) << (SH - 1))) && q[0]);
         qr = (Q_W + 1)'(q) + (Q_W + 1)'(up);
         if (qr > (Q_W + 1)'(255)) begin
            qr = (Q_W + 1)'(255);
         end
         if (s5_ctrl_ff.in_frame && (c == 0 || color_mode == COLOR_RGB)) begin
            pix_in[c*CH_W +: CH_W] = qr[CH_W-1:0];
         end
      end
   end

   // Output register: one-cycle result strobe
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s5_ctrl_ff.valid;
      end
      rsp_pixel_ff  <= pix_in;
      rsp_inside_ff <= s5_ctrl_ff.in_frame;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule

// File: sv/bilinear_remap_sampler_core.sv
// Bilinear remap sampler. Takes one transaction per clock (busy never rises):
// a write stores one pixel, a sample returns one interpolated pixel on rsp_*
// with rsp_valid high for one cycle; a request passes the stage 1, stage 2,
// bank read (stage 3), stage 4, stage 5 and output registers, and results return in order.
// The frame store is split into four banks by row and column parity so
// all four neighbors are read in parallel; a sample sees every write accepted
// before it. The store is not cleared: sampling pixels never written gives
// undefined data. The result side cannot stall, so the receiver must take every
// strobe. Configuration writes are always ready and are meant for idle periods.
module bilinear_remap_sampler_core import brs_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_mode,
   input  logic [POS_IN_W-1:0]       req_write_col,
   input  logic [POS_IN_W-1:0]       req_write_row,
   input  logic [PIX_W-1:0]          req_pixel_in,
   input  logic signed [COORD_W-1:0] req_sample_x,
   input  logic signed [COORD_W-1:0] req_sample_y,
   output logic                      rsp_valid,
   output logic [PIX_W-1:0]          rsp_pixel_out,
   output logic                      rsp_inside_res,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CFG_W-1:0]          csr_data
);

   localparam int DIM_W      = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
   localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int WT_W       = 2 * FRAC_BITS + 1;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers, dimensions held already clamped
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic             color_ff;
   logic [DIM_W-1:0] width_in;
   logic [DIM_W-1:0] height_in;
   logic             csr_wr;

   always_comb begin
      csr_wr    = csr_valid && csr_ready;
      width_in  = DIM_W'(clamp_dim(int'(csr_data), MAX_WIDTH));
      height_in = DIM_W'(clamp_dim(int'(csr_data), MAX_HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(clamp_dim(DIM_RESET, MAX_WIDTH));
         height_ff <= DIM_W'(clamp_dim(DIM_RESET, MAX_HEIGHT));
         color_ff  <= COLOR_GREY;
      end else if (csr_wr) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               width_ff <= width_in;
            end
            REG_FRAME_HEIGHT: begin
               height_ff <= height_in;
            end
            REG_COLOR_MODE: begin
               color_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Decode and addressing stages
   logic [BA_W-1:0]      bank_addr [NUM_BANKS];
   logic [NUM_BANKS-1:0] bank_wr_en;
   logic [PIX_W-1:0]     bank_wr_data;
   logic [PIX_W-1:0]     bank_rd_data [NUM_BANKS];
   brs_ctrl_type         ctrl;
   logic [WT_W-1:0]      weight [4];

   brs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start && !busy),
      .req_mode      (req_mode),
      .req_write_col (req_write_col),
      .req_write_row (req_write_row),
      .req_pixel_in  (req_pixel_in),
      .req_sample_x  (req_sample_x),
      .req_sample_y  (req_sample_y),
      .frame_width   (width_ff),
      .frame_height  (height_ff),
      .bank_addr     (bank_addr),
      .bank_wr_en    (bank_wr_en),
      .bank_wr_data  (bank_wr_data),
      .ctrl          (ctrl),
      .weight        (weight)
   );

   // Four parity banks of the frame store
   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      brs_ram #(
         .WIDTH (PIX_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_wr_en[b]),
         .wr_addr (bank_addr[b]),
         .wr_data (bank_wr_data),
         .rd_addr (bank_addr[b]),
         .rd_data (bank_rd_data[b])
      );
   end

   // Interpolation, rounding and result register
   brs_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock          (clock),
      .reset          (reset),
      .bank_data      (bank_rd_data),
      .ctrl           (ctrl),
      .weight         (weight),
      .color_mode     (color_ff),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_inside_res (rsp_inside_res)
   );

endmodule
